// ===== sv/rlpd_pkg.sv =====
// Shared types, codes and sizes for the run-length pixel decoder.
package rlpd_pkg;

	localparam int unsigned TOTAL_W = 25;
	localparam int unsigned COUNT_W = 20;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam int unsigned OUTQ_DEPTH = 4;
	localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	localparam logic [3:0] CLS_LIT_SHORT  = 4'h0;
	localparam logic [3:0] CLS_LIT_MID    = 4'h1;
	localparam logic [3:0] CLS_LIT_LONG   = 4'h2;
	localparam logic [3:0] CLS_FILL_SHORT = 4'h8;
	localparam logic [3:0] CLS_FILL_MID   = 4'h9;
	localparam logic [3:0] CLS_FILL_LONG  = 4'ha;
	localparam logic [3:0] CLS_ZERO_SHORT = 4'hc;
	localparam logic [3:0] CLS_ZERO_MID   = 4'hd;
	localparam logic [3:0] CLS_ZERO_LONG  = 4'he;

	localparam logic [1:0] ST_EXACT     = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_LONG      = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_VALUE     = 3'd1,
		PH_COUNT_TWO = 3'd2,
		PH_COUNT_ONE = 3'd3,
		PH_LITERAL   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} src_item_t;

	typedef struct packed {
		logic [7:0]         pixel_value;
		logic [COUNT_W-1:0] run_length;
		logic               end_of_block;
		logic [1:0]         status;
		logic [TOTAL_W-1:0] total_length;
	} dst_item_t;

endpackage

// ===== sv/rlpd_outq.sv =====
// Result queue that takes up to two transactions per cycle and hands out one while dst_stall is low.
module rlpd_outq import rlpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] push_cnt,
	input  dst_item_t push_a,
	input  dst_item_t push_b,
	output logic      room_two,
	output logic      dst_valid,
	input  logic      dst_stall,
	output dst_item_t dst_item
);

	dst_item_t               mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]   wr_ptr_q;
	logic [OUTQ_PTR_W-1:0]   rd_ptr_q;
	logic [OUTQ_CNT_W-1:0]   count_q;
	logic                    pop;
	logic [OUTQ_PTR_W-1:0]   wr_ptr_b;

	assign pop       = dst_valid & ~dst_stall;
	assign dst_valid = (count_q != '0);
	assign dst_item  = mem_q[rd_ptr_q];
	assign room_two  = (count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
	assign wr_ptr_b  = wr_ptr_q + OUTQ_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_b] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			count_q <= count_q + OUTQ_CNT_W'(push_cnt) - OUTQ_CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room_two)
		else $error("push into a queue without room");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd0 && !pop) |=> $stable(count_q))
		else $error("queue count moved while idle");
`endif

endmodule

// ===== sv/run_length_pixel_decoder.sv =====
// Run-length pixel decoder: token parser, length totals and result queue.
// A byte accepted into the input register is decoded there and written into the result queue,
// which hands out one result per cycle while dst_stall is low. Throughput: one byte per cycle
// while the queue has room for two results; a byte that yields a run and the end summary pushes
// two results, and the four-entry result queue sets how long that burst can be absorbed.
// Reset clears the token state, the totals, the queue and expected_length to zero.
module run_length_pixel_decoder import rlpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  src_item_t          src_item,
	output logic               dst_valid,
	input  logic               dst_stall,
	output dst_item_t          dst_item,
	input  logic               cfg_we,
	input  logic [TOTAL_W-1:0] cfg_data
);

	src_item_t          item_s1;
	logic               vld_s1;
	logic               adv;
	logic [1:0]         push_cnt;
	logic               room_two;

	logic [TOTAL_W-1:0] expected_q;
	phase_t             phase_q;
	logic [3:0]         cls_q;
	logic [COUNT_W-1:0] acc_q;
	logic [COUNT_W-1:0] lit_rem_q;
	logic [7:0]         fill_q;
	logic [TOTAL_W-1:0] total_q;
	logic               malformed_q;

	phase_t             phase_d;
	logic [3:0]         cls_d;
	logic [COUNT_W-1:0] acc_d;
	logic [COUNT_W-1:0] lit_rem_d;
	logic [7:0]         fill_d;
	logic               fin;
	logic               bad;
	logic               run_v;
	logic [7:0]         run_val;
	logic [COUNT_W-1:0] run_cnt;
	logic               cls_is_lit;
	logic               cls_is_fill;

	logic [TOTAL_W:0]   sum_w;
	logic [TOTAL_W-1:0] total_d;
	logic               malformed_d;
	logic [1:0]         status_d;
	dst_item_t          run_item;
	dst_item_t          sum_item;
	dst_item_t          push_a;
	logic [7:0]         b;

	assign b         = item_s1.data_byte;
	assign adv       = vld_s1 & room_two;
	assign src_stall = vld_s1 & ~room_two;

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (src_valid & ~src_stall) | (vld_s1 & ~adv);
		end
	end

	assign cls_is_lit  = (cls_d <= CLS_LIT_LONG);
	assign cls_is_fill = (cls_d == CLS_FILL_SHORT) || (cls_d == CLS_FILL_MID) ||
		(cls_d == CLS_FILL_LONG);

	// Token datapath: count, class, fill value and the run a byte produces.
	always_comb begin
		cls_d     = cls_q;
		acc_d     = acc_q;
		lit_rem_d = lit_rem_q;
		fill_d    = fill_q;
		fin       = 1'b0;
		bad       = 1'b0;
		run_v     = 1'b0;
		run_val   = 8'd0;
		run_cnt   = '0;
		unique case (phase_q)
			PH_VALUE: begin
				fill_d = b;
				fin    = (cls_q != CLS_FILL_MID) && (cls_q != CLS_FILL_LONG);
			end
			PH_COUNT_TWO: begin
				acc_d = {acc_q[COUNT_W-9:0], b};
			end
			PH_COUNT_ONE: begin
				acc_d = {acc_q[COUNT_W-9:0], b};
				fin   = 1'b1;
			end
			PH_LITERAL: begin
				run_v     = 1'b1;
				run_val   = b;
				run_cnt   = COUNT_W'(1);
				lit_rem_d = lit_rem_q - COUNT_W'(1);
			end
			default: begin
				cls_d = b[7:4];
				acc_d = COUNT_W'(b[3:0]);
				unique case (b[7:4])
					CLS_LIT_SHORT, CLS_ZERO_SHORT: fin = 1'b1;
					CLS_LIT_MID, CLS_LIT_LONG, CLS_FILL_SHORT, CLS_FILL_MID,
					CLS_FILL_LONG, CLS_ZERO_MID, CLS_ZERO_LONG: fin = 1'b0;
					default: begin
						bad   = 1'b1;
						cls_d = 4'd0;
						acc_d = '0;
					end
				endcase
			end
		endcase
		if (fin) begin
			if (cls_is_lit) begin
				lit_rem_d = acc_d;
			end else if (acc_d != '0) begin
				run_v   = 1'b1;
				run_val = cls_is_fill ? fill_d : 8'd0;
				run_cnt = acc_d;
			end
		end
	end

	// Next token phase.
	always_comb begin
		phase_d = phase_q;
		if (fin) begin
			phase_d = (cls_is_lit && acc_d != '0) ? PH_LITERAL : PH_HEADER;
		end else begin
			unique case (phase_q)
				PH_VALUE:     phase_d = (cls_q == CLS_FILL_MID) ? PH_COUNT_ONE : PH_COUNT_TWO;
				PH_COUNT_TWO: phase_d = PH_COUNT_ONE;
				PH_COUNT_ONE: phase_d = PH_HEADER;
				PH_LITERAL:   phase_d = (lit_rem_d == '0) ? PH_HEADER : PH_LITERAL;
				default: begin
					unique case (b[7:4])
						CLS_FILL_SHORT, CLS_FILL_MID, CLS_FILL_LONG: phase_d = PH_VALUE;
						CLS_LIT_MID, CLS_ZERO_MID:                   phase_d = PH_COUNT_ONE;
						CLS_LIT_LONG, CLS_ZERO_LONG:                 phase_d = PH_COUNT_TWO;
						default:                                     phase_d = PH_HEADER;
					endcase
				end
			endcase
		end
	end

	assign sum_w   = {1'b0, total_q} + (TOTAL_W + 1)'(run_cnt);
	assign total_d = (run_v && sum_w >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX :
		(run_v ? sum_w[TOTAL_W-1:0] : total_q);
	assign malformed_d = malformed_q | bad | (phase_d != PH_HEADER);

	always_comb begin
		priority if (malformed_d) begin
			status_d = ST_MALFORMED;
		end else if (total_d < expected_q) begin
			status_d = ST_SHORT;
		end else if (total_d > expected_q) begin
			status_d = ST_LONG;
		end else begin
			status_d = ST_EXACT;
		end
	end

	always_comb begin
		run_item.pixel_value  = run_val;
		run_item.run_length   = run_cnt;
		run_item.end_of_block = 1'b0;
		run_item.status       = ST_EXACT;
		run_item.total_length = total_d;
		sum_item.pixel_value  = 8'd0;
		sum_item.run_length   = '0;
		sum_item.end_of_block = 1'b1;
		sum_item.status       = status_d;
		sum_item.total_length = total_d;
	end

	assign push_a   = run_v ? run_item : sum_item;
	assign push_cnt = adv ? (2'(run_v) + 2'(item_s1.last_byte)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q  <= '0;
			phase_q     <= PH_HEADER;
			cls_q       <= '0;
			acc_q       <= '0;
			lit_rem_q   <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			malformed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				expected_q <= cfg_data;
			end
			if (adv) begin
				if (item_s1.last_byte) begin
					phase_q     <= PH_HEADER;
					cls_q       <= '0;
					acc_q       <= '0;
					lit_rem_q   <= '0;
					fill_q      <= '0;
					total_q     <= '0;
					malformed_q <= 1'b0;
				end else begin
					phase_q     <= phase_d;
					cls_q       <= cls_d;
					acc_q       <= acc_d;
					lit_rem_q   <= lit_rem_d;
					fill_q      <= fill_d;
					total_q     <= total_d;
					malformed_q <= malformed_q | bad;
				end
			end
		end
	end

	rlpd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_a    (push_a),
		.push_b    (sum_item),
		.room_two  (room_two),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

`ifndef SYNTHESIS
	a_literal_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL) |-> (lit_rem_q != '0))
		else $error("literal phase with nothing left");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.last_byte) |=>
		(phase_q == PH_HEADER && total_q == '0 && !malformed_q))
		else $error("block state not cleared after summary");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !item_s1.last_byte) |=> (total_q >= $past(total_q)))
		else $error("decoded total decreased within a block");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_v |-> (run_cnt != '0))
		else $error("run with zero count");
`endif

endmodule

// ===== tb/rlpd_run_checker.sv =====
// Stream checker for the run-length pixel decoder: predicts run and summary items and compares.
module rlpd_run_checker import rlpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic               src_stall,
	input  src_item_t          src_item,
	input  logic               dst_valid,
	input  logic               dst_stall,
	input  dst_item_t          dst_item,
	input  logic               cfg_we,
	input  logic [TOTAL_W-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending
);

	phase_t             phase;
	logic [3:0]         cls;
	logic [COUNT_W-1:0] count_acc;
	logic [COUNT_W-1:0] literal_left;
	logic [7:0]         fill_byte;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] length_goal;
	bit                 bad_block;
	dst_item_t          pending_runs[$];
	int                 fails = 0;
	int                 waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	task automatic report(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	task automatic clear_block();
		phase        = PH_HEADER;
		cls          = '0;
		count_acc    = '0;
		literal_left = '0;
		fill_byte    = '0;
		total        = '0;
		bad_block    = 1'b0;
	endtask

	task automatic emit_run(input logic [7:0] value, input logic [COUNT_W-1:0] count);
		dst_item_t r;
		logic [TOTAL_W-1:0] room;
		room = TOTAL_MAX - total;
		total = ({{(TOTAL_W-COUNT_W){1'b0}}, count} >= room) ? TOTAL_MAX :
			total + TOTAL_W'(count);
		r.pixel_value  = value;
		r.run_length   = count;
		r.end_of_block = 1'b0;
		r.status       = ST_EXACT;
		r.total_length = total;
		pending_runs = {pending_runs, r};
	endtask

	task automatic close_token();
		phase = PH_HEADER;
		if (cls <= CLS_LIT_LONG) begin
			literal_left = count_acc;
			if (count_acc != 0) begin
				phase = PH_LITERAL;
			end
		end else if (cls >= CLS_FILL_SHORT && cls <= CLS_FILL_LONG) begin
			if (count_acc != 0) begin
				emit_run(fill_byte, count_acc);
			end
		end else if (count_acc != 0) begin
			emit_run(8'h00, count_acc);
		end
	endtask

	task automatic decode_byte(input src_item_t it);
		dst_item_t r;
		logic [7:0] b;
		b = it.data_byte;
		case (phase)
			PH_VALUE: begin
				fill_byte = b;
				if (cls == CLS_FILL_MID) begin
					phase = PH_COUNT_ONE;
				end else if (cls == CLS_FILL_LONG) begin
					phase = PH_COUNT_TWO;
				end else begin
					close_token();
				end
			end
			PH_COUNT_TWO: begin
				count_acc = {count_acc[COUNT_W-9:0], b};
				phase = PH_COUNT_ONE;
			end
			PH_COUNT_ONE: begin
				count_acc = {count_acc[COUNT_W-9:0], b};
				close_token();
			end
			PH_LITERAL: begin
				emit_run(b, 20'd1);
				literal_left = literal_left - COUNT_W'(1);
				if (literal_left == 0) begin
					phase = PH_HEADER;
				end
			end
			default: begin
				cls = b[7:4];
				count_acc = {{(COUNT_W-4){1'b0}}, b[3:0]};
				case (b[7:4])
					CLS_LIT_SHORT, CLS_ZERO_SHORT: close_token();
					CLS_FILL_SHORT, CLS_FILL_MID, CLS_FILL_LONG: phase = PH_VALUE;
					CLS_LIT_MID, CLS_ZERO_MID: phase = PH_COUNT_ONE;
					CLS_LIT_LONG, CLS_ZERO_LONG: phase = PH_COUNT_TWO;
					default: begin
						// skip unknown header, flag the block
						bad_block = 1'b1;
						cls = '0;
						count_acc = '0;
						phase = PH_HEADER;
					end
				endcase
			end
		endcase
		if (it.last_byte) begin
			if (phase != PH_HEADER) begin
				bad_block = 1'b1;
			end
			r.pixel_value  = 8'h00;
			r.run_length   = '0;
			r.end_of_block = 1'b1;
			if (bad_block) begin
				r.status = ST_MALFORMED;
			end else if (total < length_goal) begin
				r.status = ST_SHORT;
			end else if (total > length_goal) begin
				r.status = ST_LONG;
			end else begin
				r.status = ST_EXACT;
			end
			r.total_length = total;
			pending_runs = {pending_runs, r};
			clear_block();
		end
	endtask

	task automatic check_result(input dst_item_t got);
		dst_item_t want;
		if (pending_runs.size() == 0) begin
			report($sformatf("result %h with nothing pending", got));
		end else begin
			want = pending_runs.pop_front();
			check_field("pixel_value", 32'(got.pixel_value), 32'(want.pixel_value));
			check_field("run_length", 32'(got.run_length), 32'(want.run_length));
			check_field("end_of_block", 32'(got.end_of_block), 32'(want.end_of_block));
			check_field("status", 32'(got.status), 32'(want.status));
			check_field("total_length", 32'(got.total_length), 32'(want.total_length));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_block();
			length_goal = '0;
			pending_runs.delete();
			waiting = 0;
		end else begin
			if (dst_valid && !dst_stall) begin
				check_result(dst_item);
			end
			if (src_valid && !src_stall) begin
				decode_byte(src_item);
			end
			if (cfg_we) begin
				length_goal = cfg_data;
			end
			waiting = pending_runs.size();
		end
	end

endmodule

// ===== tb/tb_run_length_pixel_decoder.sv =====
// Testbench top for the run-length pixel decoder: clock, reset, stimulus and verdict.
module tb_run_length_pixel_decoder;
	import rlpd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEM_TARGET  = 1450;
	localparam logic [3:0] CLS_UNUSED = 4'h7;

	logic               clk;
	logic               arst_n;
	logic               src_valid;
	logic               src_stall;
	src_item_t          src_item;
	logic               dst_valid;
	logic               dst_stall = 1'b0;
	dst_item_t          dst_item;
	logic               cfg_we;
	logic [TOTAL_W-1:0] cfg_data;

	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	bit          quiet = 1'b0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          decoded_items = 0;
	int unsigned block_total = 0;
	src_item_t   stream_q[$];

	run_length_pixel_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	rlpd_run_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			dst_stall = 1'b1;
			hold_left--;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
			dst_stall = 1'b1;
		end else begin
			dst_stall = !quiet && ($urandom_range(99) < 20);
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit counted);
		src_item_t it;
		it.data_byte = b;
		it.last_byte = 1'b0;
		stream_q = {stream_q, it};
		if (counted) begin
			decoded_items++;
		end
	endtask

	task automatic mark_last();
		stream_q[stream_q.size() - 1].last_byte = 1'b1;
	endtask

	task automatic add_count(input int unsigned n);
		block_total = (block_total + n > 32'(TOTAL_MAX)) ? 32'(TOTAL_MAX) : block_total + n;
	endtask

	task automatic push_literal(input int unsigned n);
		repeat (n) begin
			push_byte(8'($urandom), 1'b1);
		end
		add_count(n);
	endtask

	task automatic push_token();
		int unsigned n;
		int unsigned m;
		int unsigned z;
		logic [3:0] nib;
		n = $urandom_range(15);
		m = $urandom_range(255);
		z = $urandom_range(255);
		if ($urandom_range(99) < 8) begin
			do begin
				nib = 4'($urandom_range(15));
			end while (nib inside {CLS_LIT_SHORT, CLS_LIT_MID, CLS_LIT_LONG, CLS_FILL_SHORT,
				CLS_FILL_MID, CLS_FILL_LONG, CLS_ZERO_SHORT, CLS_ZERO_MID, CLS_ZERO_LONG});
			push_byte({nib, n[3:0]}, 1'b0);
		end else begin
			case ($urandom_range(8))
				0: begin
					push_byte({CLS_LIT_SHORT, n[3:0]}, 1'b1);
					push_literal(n);
				end
				1: begin
					m = $urandom_range(24);
					push_byte({CLS_LIT_MID, 4'h0}, 1'b1);
					push_byte(m[7:0], 1'b1);
					push_literal(m);
				end
				2: begin
					z = $urandom_range(12);
					push_byte({CLS_LIT_LONG, 4'h0}, 1'b1);
					push_byte(8'h00, 1'b1);
					push_byte(z[7:0], 1'b1);
					push_literal(z);
				end
				3: begin
					push_byte({CLS_FILL_SHORT, n[3:0]}, 1'b1);
					push_byte(8'($urandom), 1'b1);
					add_count(n);
				end
				4: begin
					push_byte({CLS_FILL_MID, n[3:0]}, 1'b1);
					push_byte(8'($urandom), 1'b1);
					push_byte(m[7:0], 1'b1);
					add_count(n * 256 + m);
				end
				5: begin
					push_byte({CLS_FILL_LONG, n[3:0]}, 1'b1);
					push_byte(8'($urandom), 1'b1);
					push_byte(m[7:0], 1'b1);
					push_byte(z[7:0], 1'b1);
					add_count(n * 65536 + m * 256 + z);
				end
				6: begin
					push_byte({CLS_ZERO_SHORT, n[3:0]}, 1'b1);
					add_count(n);
				end
				7: begin
					push_byte({CLS_ZERO_MID, n[3:0]}, 1'b1);
					push_byte(m[7:0], 1'b1);
					add_count(n * 256 + m);
				end
				default: begin
					push_byte({CLS_ZERO_LONG, n[3:0]}, 1'b1);
					push_byte(m[7:0], 1'b1);
					push_byte(z[7:0], 1'b1);
					add_count(n * 65536 + m * 256 + z);
				end
			endcase
		end
	endtask

	task automatic push_partial_token();
		int unsigned n;
		n = $urandom_range(2, 15);
		case ($urandom_range(4))
			0: push_byte({CLS_LIT_MID, 4'($urandom)}, 1'b1);
			1: push_byte({CLS_FILL_SHORT, 4'($urandom)}, 1'b1);
			2: begin
				push_byte({CLS_FILL_LONG, 4'($urandom)}, 1'b1);
				push_byte(8'($urandom), 1'b1);
				if ($urandom_range(1)) begin
					push_byte(8'($urandom), 1'b1);
				end
			end
			3: begin
				push_byte({CLS_ZERO_LONG, 4'($urandom)}, 1'b1);
				if ($urandom_range(1)) begin
					push_byte(8'($urandom), 1'b1);
				end
			end
			default: begin
				push_byte({CLS_LIT_SHORT, n[3:0]}, 1'b1);
				push_literal($urandom_range(0, n - 1));
			end
		endcase
	endtask

	task automatic build_block(input int tokens, input bit truncate);
		block_total = 0;
		repeat (tokens) begin
			push_token();
		end
		if (truncate) begin
			push_partial_token();
		end
		mark_last();
	endtask

	task automatic send_item(input src_item_t it);
		bit taken;
		while (!quiet && $urandom_range(99) < 20) begin
			src_valid = 1'b0;
			@(negedge clk);
		end
		src_valid = 1'b1;
		src_item = it;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !src_stall;
			@(negedge clk);
		end
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) begin
			send_item(stream_q[i]);
		end
		src_valid = 1'b0;
		stream_q.delete();
	endtask

	task automatic write_length(input logic [TOTAL_W-1:0] goal);
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = goal;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int phase_no;
		logic [TOTAL_W-1:0] goal;
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_item  = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short tokens, zero counts, unknown header, reset length
		push_byte({CLS_LIT_SHORT, 4'h2}, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte({CLS_FILL_SHORT, 4'h0}, 1'b1);
		push_byte(8'h55, 1'b1);
		push_byte({CLS_FILL_SHORT, 4'hf}, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte({CLS_ZERO_SHORT, 4'h0}, 1'b1);
		push_byte({CLS_ZERO_SHORT, 4'hf}, 1'b1);
		push_byte({CLS_UNUSED, 4'h0}, 1'b0);
		push_byte({CLS_ZERO_MID, 4'h0}, 1'b1);
		push_byte(8'h01, 1'b1);
		mark_last();
		send_stream();

		// largest counts against the largest length
		push_byte({CLS_FILL_LONG, 4'hf}, 1'b1);
		push_byte(8'h12, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte({CLS_ZERO_LONG, 4'hf}, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte({CLS_FILL_MID, 4'hf}, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b1);
		push_byte({CLS_LIT_LONG, 4'h0}, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'h01, 1'b1);
		push_byte(8'h7e, 1'b1);
		mark_last();
		write_length(TOTAL_MAX);
		send_stream();

		// saturate the running total
		block_total = 0;
		repeat (34) begin
			push_byte({CLS_FILL_LONG, 4'hf}, 1'b1);
			push_byte(8'($urandom), 1'b1);
			push_byte(8'hff, 1'b1);
			push_byte(8'hff, 1'b1);
		end
		push_byte({CLS_ZERO_SHORT, 4'hf}, 1'b1);
		mark_last();
		write_length(TOTAL_MAX);
		send_stream();

		// hold the receiver off while literal bytes keep coming
		block_total = 0;
		push_byte({CLS_LIT_MID, 4'h0}, 1'b1);
		push_byte(8'd40, 1'b1);
		push_literal(40);
		push_byte({CLS_ZERO_SHORT, 4'h0}, 1'b1);
		mark_last();
		write_length(TOTAL_W'(block_total));
		hold_req++;
		send_stream();

		// literal with a nonzero high count nibble
		block_total = 0;
		push_byte({CLS_LIT_MID, 4'h1}, 1'b1);
		push_byte(8'h00, 1'b1);
		push_literal(256);
		mark_last();
		write_length(TOTAL_W'(block_total));
		send_stream();

		phase_no = 0;
		while (decoded_items < ITEM_TARGET) begin
			repeat ($urandom_range(1, 2)) begin
				build_block($urandom_range(1, 10), $urandom_range(9) == 0);
			end
			case ($urandom_range(9))
				0, 1, 2: goal = TOTAL_W'(block_total);
				3: goal = (block_total > 0) ? TOTAL_W'(block_total - 1) : '0;
				4: goal = (block_total < 32'(TOTAL_MAX)) ? TOTAL_W'(block_total + 1) :
					TOTAL_W'(block_total);
				5: goal = '0;
				6: goal = TOTAL_MAX;
				default: goal = TOTAL_W'($urandom);
			endcase
			write_length(goal);
			quiet = (phase_no >= 6 && phase_no < 12);
			send_stream();
			quiet = 1'b0;
			phase_no++;
		end

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
